// ----- rtl/vmv_pkg.sv -----
// Package for the vector median-of-three voter: value type, codes and lane count.
`default_nettype none
package vmv_pkg;

  // Width of one component value (signed Q16.16)
  localparam int unsigned VALUE_W = 32;
  // Components per vector, one voting lane each
  localparam int unsigned NUM_LANES = 3;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [NUM_LANES-1:0]      valid_t;

  // Infinity codes: most negative and most positive values
  localparam value_t NEG_INF = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam value_t POS_INF = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam value_t ZERO    = '0;

  // Which sources are valid for one component: bit0 a, bit1 b, bit2 c
  localparam logic [2:0] SEL_NONE = 3'b000;
  localparam logic [2:0] SEL_A    = 3'b001;
  localparam logic [2:0] SEL_B    = 3'b010;
  localparam logic [2:0] SEL_AB   = 3'b011;
  localparam logic [2:0] SEL_C    = 3'b100;
  localparam logic [2:0] SEL_AC   = 3'b101;
  localparam logic [2:0] SEL_BC   = 3'b110;
  localparam logic [2:0] SEL_ABC  = 3'b111;

endpackage
`default_nettype wire

// ----- rtl/vmv_if.sv -----
// Handshake interfaces for the voter: input item of three vectors, output voted vector.
`default_nettype none
interface vmv_in_if;
  logic          valid;
  logic          ready;
  vmv_pkg::value_t a_x, a_y, a_z;
  vmv_pkg::value_t b_x, b_y, b_z;
  vmv_pkg::value_t c_x, c_y, c_z;
  vmv_pkg::valid_t a_valid, b_valid, c_valid;

  modport source (
    output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
           a_valid, b_valid, c_valid,
    input  ready
  );
  modport sink (
    input  valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
           a_valid, b_valid, c_valid,
    output ready
  );
endinterface

interface vmv_out_if;
  logic          valid;
  logic          ready;
  vmv_pkg::value_t m_x, m_y, m_z;

  modport source (output valid, m_x, m_y, m_z, input ready);
  modport sink   (input valid, m_x, m_y, m_z, output ready);
endinterface
`default_nettype wire

// ----- rtl/vmv_lane.sv -----
// One voting lane: median, mean or pass-through of one component from three sources, or zero if none is valid.
`default_nettype none
module vmv_lane (
  input  vmv_pkg::value_t a,
  input  vmv_pkg::value_t b,
  input  vmv_pkg::value_t c,
  input  logic [2:0]      sel,
  output vmv_pkg::value_t res
);

  logic            ab_lt, bc_lt, ac_lt;
  vmv_pkg::value_t med;
  vmv_pkg::value_t p, q;
  logic            p_inf, q_inf;
  logic signed [vmv_pkg::VALUE_W:0] sum;
  vmv_pkg::value_t mean;
  vmv_pkg::value_t pair;

  // Median of three: three signed compares in parallel
  assign ab_lt = (a < b);
  assign bc_lt = (b < c);
  assign ac_lt = (a < c);

  always_comb begin
    if (ab_lt) begin
      if (bc_lt)      med = b;
      else if (ac_lt) med = c;
      else            med = a;
    end else begin
      if (ac_lt)      med = a;
      else if (bc_lt) med = c;
      else            med = b;
    end
  end

  // Pick the two valid operands for the two-source case
  always_comb begin
    case (sel)
      vmv_pkg::SEL_AB: begin p = a; q = b; end
      vmv_pkg::SEL_AC: begin p = a; q = c; end
      default:         begin p = b; q = c; end
    endcase
  end

  assign p_inf = (p == vmv_pkg::NEG_INF) || (p == vmv_pkg::POS_INF);
  assign q_inf = (q == vmv_pkg::NEG_INF) || (q == vmv_pkg::POS_INF);

  // Floor mean through one extra bit, arithmetic shift drops the half
  assign sum  = {p[vmv_pkg::VALUE_W-1], p} + {q[vmv_pkg::VALUE_W-1], q};
  assign mean = sum[vmv_pkg::VALUE_W:1];

  // Infinities win over the mean; opposite infinities cancel to zero
  always_comb begin
    if (p_inf && q_inf) pair = (p == q) ? p : vmv_pkg::ZERO;
    else if (p_inf)     pair = p;
    else if (q_inf)     pair = q;
    else                pair = mean;
  end

  // Select by the number of valid sources
  always_comb begin
    case (sel)
      vmv_pkg::SEL_ABC: res = med;
      vmv_pkg::SEL_AB,
      vmv_pkg::SEL_AC,
      vmv_pkg::SEL_BC:  res = pair;
      vmv_pkg::SEL_A:   res = a;
      vmv_pkg::SEL_B:   res = b;
      vmv_pkg::SEL_C:   res = c;
      default:          res = vmv_pkg::ZERO;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/vmv_merge.sv -----
// Merge stage: collects the lane results into one output item register.
`default_nettype none
module vmv_merge (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  vmv_pkg::value_t   lane_res [vmv_pkg::NUM_LANES],
  vmv_out_if.source         voted
);

  logic            out_valid;
  vmv_pkg::value_t m_x, m_y, m_z;

  // Load whenever the register is empty or being drained this cycle
  assign in_ready = !out_valid || voted.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      m_x <= lane_res[0];
      m_y <= lane_res[1];
      m_z <= lane_res[2];
    end
  end

  assign voted.valid = out_valid;
  assign voted.m_x   = m_x;
  assign voted.m_y   = m_y;
  assign voted.m_z   = m_z;

endmodule
`default_nettype wire

// ----- rtl/vector_median_of_three_voter_unit.sv -----
// Top level of the vector median-of-three voter: three lanes and the merge stage.
`default_nettype none
// Votes three redundant x/y/z vectors one component at a time. Each component
// is signed Q16.16; the most negative and most positive codes mean -inf and
// +inf, and a clear valid bit marks a NaN. Three valid values give the median,
// two give the floor mean (a lone infinity passes, opposite infinities give
// 0), one gives itself, none gives 0. The result appears on the output in the
// cycle after acceptance; one item is accepted every cycle while the receiver
// takes results, since the three component lanes run in parallel and feed a
// single output register that reloads while its current result is being taken.
module vector_median_of_three_voter_unit (
  input  logic      clk,
  input  logic      rst,
  vmv_in_if.sink    samples,
  vmv_out_if.source voted
);

  vmv_pkg::value_t a_v [vmv_pkg::NUM_LANES];
  vmv_pkg::value_t b_v [vmv_pkg::NUM_LANES];
  vmv_pkg::value_t c_v [vmv_pkg::NUM_LANES];
  vmv_pkg::value_t lane_res [vmv_pkg::NUM_LANES];
  logic            in_ready;

  // Spread the item's components over the lanes
  assign a_v[0] = samples.a_x;
  assign a_v[1] = samples.a_y;
  assign a_v[2] = samples.a_z;
  assign b_v[0] = samples.b_x;
  assign b_v[1] = samples.b_y;
  assign b_v[2] = samples.b_z;
  assign c_v[0] = samples.c_x;
  assign c_v[1] = samples.c_y;
  assign c_v[2] = samples.c_z;

  for (genvar k = 0; k < vmv_pkg::NUM_LANES; k++) begin : g_lane
    vmv_lane u_lane (
      .a   (a_v[k]),
      .b   (b_v[k]),
      .c   (c_v[k]),
      .sel ({samples.c_valid[k], samples.b_valid[k], samples.a_valid[k]}),
      .res (lane_res[k])
    );
  end

  vmv_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .lane_res (lane_res),
    .voted    (voted)
  );

  assign samples.ready = in_ready;

`ifndef NO_ASSERTIONS
  // An accepted item always shows up at the output the next cycle
  assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> voted.valid)
    else $error("accepted item not presented");

  // Unanimous valid x values vote to that value
  assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready && samples.a_valid[0] && samples.b_valid[0]
      && samples.c_valid[0] && samples.a_x == samples.b_x && samples.b_x == samples.c_x
    |=> voted.m_x == $past(samples.a_x))
    else $error("unanimous x vote differs");

  // No valid y source gives zero
  assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready && !samples.a_valid[1] && !samples.b_valid[1]
      && !samples.c_valid[1]
    |=> voted.m_y == vmv_pkg::ZERO)
    else $error("all-NaN y not zero");

  // Reset empties the output register
  assert property (@(posedge clk) rst |=> !voted.valid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

// ----- dv/vmv_vote_checker.sv -----
// Checker for the voter: predicts each voted vector from the accepted items and compares outputs.
`default_nettype none
module vmv_vote_checker (
  input  logic clk,
  input  logic rst,
  vmv_in_if    samples,
  vmv_out_if   voted,
  output int   failures,
  output int   pending,
  output int   checked
);

  typedef struct packed {
    vmv_pkg::value_t x;
    vmv_pkg::value_t y;
    vmv_pkg::value_t z;
  } voted_vec_t;

  voted_vec_t      voted_expect_q[$];
  voted_vec_t      want;
  vmv_pkg::value_t want_f[3];
  vmv_pkg::value_t got_f[3];
  string           field_name[3] = '{"m_x", "m_y", "m_z"};

  // Two valid values: floor mean, with infinity codes handled first
  function automatic vmv_pkg::value_t pair_vote(vmv_pkg::value_t p, vmv_pkg::value_t q);
    logic                             p_inf;
    logic                             q_inf;
    logic signed [vmv_pkg::VALUE_W:0] sum;
    p_inf = (p == vmv_pkg::NEG_INF) || (p == vmv_pkg::POS_INF);
    q_inf = (q == vmv_pkg::NEG_INF) || (q == vmv_pkg::POS_INF);
    sum   = {p[vmv_pkg::VALUE_W-1], p} + {q[vmv_pkg::VALUE_W-1], q};
    if (p_inf && q_inf) begin
      // opposite infinities cancel, equal ones pass
      return (p != q) ? vmv_pkg::ZERO : p;
    end else if (p_inf) begin
      return p;
    end else if (q_inf) begin
      return q;
    end
    return sum[vmv_pkg::VALUE_W:1];
  endfunction

  // One component: pick the vote by which sources are valid
  function automatic vmv_pkg::value_t vote_lane(vmv_pkg::value_t a, vmv_pkg::value_t b,
                                                vmv_pkg::value_t c, logic [2:0] sel);
    vmv_pkg::value_t lo;
    vmv_pkg::value_t hi;
    case (sel)
      vmv_pkg::SEL_NONE: return vmv_pkg::ZERO;
      vmv_pkg::SEL_A:    return a;
      vmv_pkg::SEL_B:    return b;
      vmv_pkg::SEL_C:    return c;
      vmv_pkg::SEL_AB:   return pair_vote(a, b);
      vmv_pkg::SEL_AC:   return pair_vote(a, c);
      vmv_pkg::SEL_BC:   return pair_vote(b, c);
      default: begin
        // median of three as max(min(a,b), min(max(a,b), c))
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        hi = (hi < c) ? hi : c;
        return (lo > hi) ? lo : hi;
      end
    endcase
  endfunction

  // Compare the output first, then queue the prediction for a new item
  always @(posedge clk) begin
    if (!rst) begin
      if (voted.valid && voted.ready) begin
        if (voted_expect_q.size() == 0) begin
          $error("voted vector with none expected: m_x %0d m_y %0d m_z %0d",
                 voted.m_x, voted.m_y, voted.m_z);
          failures++;
        end else begin
          want      = voted_expect_q.pop_front();
          want_f[0] = want.x;
          want_f[1] = want.y;
          want_f[2] = want.z;
          got_f[0]  = voted.m_x;
          got_f[1]  = voted.m_y;
          got_f[2]  = voted.m_z;
          for (int k = 0; k < 3; k++) begin
            if (got_f[k] !== want_f[k]) begin
              $error("%s expected %0d got %0d", field_name[k], want_f[k], got_f[k]);
              failures++;
            end
          end
          checked++;
        end
      end
      if (samples.valid && samples.ready) begin
        want.x = vote_lane(samples.a_x, samples.b_x, samples.c_x,
                           {samples.c_valid[0], samples.b_valid[0], samples.a_valid[0]});
        want.y = vote_lane(samples.a_y, samples.b_y, samples.c_y,
                           {samples.c_valid[1], samples.b_valid[1], samples.a_valid[1]});
        want.z = vote_lane(samples.a_z, samples.b_z, samples.c_z,
                           {samples.c_valid[2], samples.b_valid[2], samples.a_valid[2]});
        voted_expect_q.push_back(want);
      end
      pending = voted_expect_q.size();
    end
  end

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench top for the voter: clock, reset, directed and random items, idling phases, verdict.
`default_nettype none
module tb;

  typedef struct packed {
    vmv_pkg::value_t ax, ay, az;
    vmv_pkg::value_t bx, by, bz;
    vmv_pkg::value_t cx, cy, cz;
    vmv_pkg::valid_t av, bv, cv;
  } sample_t;

  localparam int HOLD_CYCLES    = 48;
  localparam int RAND_PER_PHASE = 200;

  logic clk = 1'b0;
  logic rst;

  vmv_in_if  samples();
  vmv_out_if voted();

  int failures;
  int pending;
  int checked;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_req       = 0;
  int directed_cnt   = 0;
  int random_cnt     = 0;

  always #10 clk = ~clk;

  vector_median_of_three_voter_unit u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (samples),
    .voted   (voted)
  );

  vmv_vote_checker u_check (
    .clk      (clk),
    .rst      (rst),
    .samples  (samples),
    .voted    (voted),
    .failures (failures),
    .pending  (pending),
    .checked  (checked)
  );

  // Values biased toward the infinity codes and their neighbors
  function automatic vmv_pkg::value_t pick_value();
    case ($urandom_range(11))
      0:       return vmv_pkg::NEG_INF;
      1:       return vmv_pkg::POS_INF;
      2:       return vmv_pkg::NEG_INF + 1;
      3:       return vmv_pkg::POS_INF - 1;
      4:       return vmv_pkg::ZERO;
      5:       return vmv_pkg::value_t'(-1);
      6, 7:    return vmv_pkg::value_t'($urandom_range(512) - 256);
      default: return vmv_pkg::value_t'($urandom);
    endcase
  endfunction

  // Mostly all valid, otherwise any mix of NaN components
  function automatic vmv_pkg::valid_t pick_valid();
    return ($urandom_range(2) == 0) ? vmv_pkg::valid_t'($urandom) : vmv_pkg::valid_t'('1);
  endfunction

  function automatic sample_t rand_sample();
    sample_t s;
    s.ax = pick_value();
    s.ay = pick_value();
    s.az = pick_value();
    s.bx = ($urandom_range(4) == 0) ? s.ax : pick_value();
    s.by = ($urandom_range(4) == 0) ? s.ay : pick_value();
    s.bz = pick_value();
    s.cx = pick_value();
    s.cy = pick_value();
    s.cz = ($urandom_range(4) == 0) ? s.az : pick_value();
    s.av = pick_valid();
    s.bv = pick_valid();
    s.cv = pick_valid();
    return s;
  endfunction

  task automatic drive_payload(input sample_t s);
    samples.a_x     <= s.ax;
    samples.a_y     <= s.ay;
    samples.a_z     <= s.az;
    samples.b_x     <= s.bx;
    samples.b_y     <= s.by;
    samples.b_z     <= s.bz;
    samples.c_x     <= s.cx;
    samples.c_y     <= s.cy;
    samples.c_z     <= s.cz;
    samples.a_valid <= s.av;
    samples.b_valid <= s.bv;
    samples.c_valid <= s.cv;
  endtask

  // Offer one item, with random idle cycles first; returns at the accepting edge
  task automatic offer(input sample_t s);
    bit took;
    while ($urandom_range(99) < send_idle_pct) begin
      samples.valid <= 1'b0;
      drive_payload(rand_sample());
      @(posedge clk);
    end
    samples.valid <= 1'b1;
    drive_payload(s);
    do begin
      @(negedge clk);
      took = samples.ready;
      @(posedge clk);
    end while (!took);
  endtask

  // Same triple on every lane, rotated so each lane sees another order
  task automatic offer_triple(input vmv_pkg::value_t a, input vmv_pkg::value_t b,
                              input vmv_pkg::value_t c, input vmv_pkg::valid_t va,
                              input vmv_pkg::valid_t vb, input vmv_pkg::valid_t vc);
    sample_t s;
    s.ax = a;  s.bx = b;  s.cx = c;
    s.ay = c;  s.by = a;  s.cy = b;
    s.az = b;  s.bz = c;  s.cz = a;
    s.av = va; s.bv = vb; s.cv = vc;
    offer(s);
    directed_cnt++;
  endtask

  // Drop valid, then change idle rates away from the sampling edge
  task automatic set_phase(input int send_pct, input int recv_pct, input bit hold);
    samples.valid <= 1'b0;
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    if (hold) hold_req++;
    @(posedge clk);
  endtask

  // Receiver: random stalls, or a long hold-off when asked
  initial begin : recv_proc
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    voted.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        voted.ready <= 1'b0;
        hold_left--;
      end else begin
        voted.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Stimulus
  initial begin : stim_proc
    rst           <= 1'b1;
    samples.valid <= 1'b0;
    drive_payload(sample_t'('0));
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, infinity rules, NaN mixes
    offer_triple(vmv_pkg::ZERO, vmv_pkg::ZERO, vmv_pkg::ZERO, '1, '1, '1);
    offer_triple(vmv_pkg::NEG_INF, vmv_pkg::POS_INF, vmv_pkg::ZERO, '1, '1, '1);
    offer_triple(vmv_pkg::POS_INF, vmv_pkg::POS_INF, vmv_pkg::NEG_INF, '1, '1, '1);
    offer_triple(vmv_pkg::NEG_INF, vmv_pkg::POS_INF, vmv_pkg::value_t'(32'h1234_5678),
                 '1, '1, '0);
    offer_triple(vmv_pkg::POS_INF, vmv_pkg::value_t'(5), vmv_pkg::value_t'(32'hdead_beef),
                 '1, '1, '0);
    offer_triple(vmv_pkg::NEG_INF, vmv_pkg::NEG_INF, vmv_pkg::value_t'(32'h0f0f_0f0f),
                 '1, '1, '0);
    offer_triple(vmv_pkg::value_t'(-1), vmv_pkg::ZERO, vmv_pkg::value_t'(7), '1, '1, '0);
    offer_triple(vmv_pkg::POS_INF - 1, vmv_pkg::POS_INF - 2, vmv_pkg::ZERO, '1, '1, '0);
    offer_triple(vmv_pkg::NEG_INF + 1, vmv_pkg::NEG_INF + 2, vmv_pkg::ZERO, '1, '1, '0);
    offer_triple(vmv_pkg::NEG_INF + 1, vmv_pkg::POS_INF - 1, vmv_pkg::POS_INF, '1, '1, '0);
    offer_triple(vmv_pkg::value_t'(3), vmv_pkg::value_t'(-4), vmv_pkg::value_t'(9),
                 '1, '1, '0);
    offer_triple(vmv_pkg::value_t'(32'hffff_ffff), vmv_pkg::POS_INF, vmv_pkg::NEG_INF,
                 '0, '0, '0);
    offer_triple(vmv_pkg::value_t'(11), vmv_pkg::value_t'(-22), vmv_pkg::value_t'(33),
                 3'b001, 3'b010, 3'b100);
    offer_triple(vmv_pkg::POS_INF, vmv_pkg::NEG_INF, vmv_pkg::value_t'(-9),
                 3'b101, 3'b011, 3'b110);
    offer_triple(vmv_pkg::NEG_INF, vmv_pkg::value_t'(-9), vmv_pkg::POS_INF,
                 3'b110, 3'b101, 3'b011);
    offer_triple(vmv_pkg::value_t'(7), vmv_pkg::value_t'(7), vmv_pkg::value_t'(-3),
                 '1, '1, '1);
    offer_triple(vmv_pkg::value_t'(-5), vmv_pkg::value_t'(-5), vmv_pkg::value_t'(-5),
                 '1, '1, '1);
    // every valid pattern per lane with extreme codes
    for (int sel = 0; sel < 8; sel++) begin
      offer_triple(vmv_pkg::NEG_INF, vmv_pkg::POS_INF, vmv_pkg::POS_INF - 1,
                   sel[0] ? vmv_pkg::valid_t'('1) : vmv_pkg::valid_t'('0),
                   sel[1] ? vmv_pkg::valid_t'('1) : vmv_pkg::valid_t'('0),
                   sel[2] ? vmv_pkg::valid_t'('1) : vmv_pkg::valid_t'('0));
    end

    // random phases: none, sender idle, receiver stall, both light
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       set_phase(0, 0, 1'b1);
        1:       set_phase(60, 0, 1'b0);
        2:       set_phase(0, 60, 1'b1);
        default: set_phase(8, 8, 1'b0);
      endcase
      repeat (RAND_PER_PHASE) begin
        offer(rand_sample());
        random_cnt++;
      end
    end
    samples.valid <= 1'b0;

    // drain, then allow for the output register
    while (pending != 0) @(negedge clk);
    repeat (4) @(posedge clk);

    $display("tb: ran %0d directed and %0d random items through four idling phases",
             directed_cnt, random_cnt);
    $display("tb: compared %0d voted vectors, with long output hold-offs in two phases",
             checked);
    if (failures == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #4_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
`default_nettype wire

// ----- sim.f -----
rtl/vmv_pkg.sv
rtl/vmv_if.sv
rtl/vmv_lane.sv
rtl/vmv_merge.sv
rtl/vector_median_of_three_voter_unit.sv
dv/vmv_vote_checker.sv
dv/tb.sv
